>>> rtl/core/cpc_pkg.sv
// Package for the point-to-circle clamp: widths, request and result types, queue depths.
// Used by the top level and the front and back parts of the clamp; depends on nothing.
package cpc_pkg;

    // Coordinate width (signed fixed point; the fraction position does not alter any bit).
    localparam int COORD_WIDTH = 32;
    // Difference width, square sum width, root width, product width and radius width.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 2;
    localparam int ROOT_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;

    // Depths of the queue between front and back and of the result queue.
    localparam int JOB_DEPTH   = 4;
    localparam int OUT_DEPTH   = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord anchor_x;
        t_coord anchor_y;
        t_coord limit_radius;
    } t_request;

    typedef struct packed {
        t_coord new_x;
        t_coord new_y;
        logic   was_clamped;
    } t_result;

    // A classified request as it travels from the front part to the back part.
    typedef struct packed {
        t_coord                        point_x;
        t_coord                        point_y;
        t_coord                        anchor_x;
        t_coord                        anchor_y;
        logic signed [DIFF_WIDTH-1:0]  dx;
        logic signed [DIFF_WIDTH-1:0]  dy;
        logic [RAD_WIDTH-1:0]          radius;
        logic [SUM_WIDTH-1:0]          sum;
        logic                          clamp;
    } t_job;

endpackage

>>> rtl/core/clamp_point_to_circle_unit.sv
// Top level of the point-to-circle clamp: front part, job queue, back part and result queue.
// Depends on cpc_pkg, cpc_fifo, cpc_front and cpc_back.
//
// The unit takes one request per clock cycle and returns one result per cycle, in order,
// as long as results are popped. A request passes three front stages, the job queue, a
// square root of COORD_WIDTH+1 stages, one product stage, a division of COORD_WIDTH+1
// stages, a saturation stage and the result queue on its way to the result ports. The
// front stalls only while the job queue is full, the back only while the result queue
// is full; both queues are short register queues, and full is driven by the job queue
// alone.
module clamp_point_to_circle_unit #(
    parameter int JOB_DEPTH = cpc_pkg::JOB_DEPTH,
    parameter int OUT_DEPTH = cpc_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  cpc_pkg::t_request i_item,
    output logic              empty,
    input  logic              pop,
    output cpc_pkg::t_result  o_result
);

    logic             front_v;
    cpc_pkg::t_job    front_job;
    logic             job_full;
    logic             job_empty;
    cpc_pkg::t_job    job_head;
    logic             job_take;
    logic             back_v;
    cpc_pkg::t_result back_result;
    logic             out_full;

    assign full = job_full;

    // Front part: requests enter while the job queue has room.
    cpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push && !job_full),
        .i_req   (i_item),
        .i_stall (job_full),
        .o_valid (front_v),
        .o_job   (front_job)
    );

    // Queue of classified requests between the two parts.
    cpc_fifo #(
        .t_item (cpc_pkg::t_job),
        .DEPTH  (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_v && !job_full),
        .i_data  (front_job),
        .o_full  (job_full),
        .i_pop   (job_take),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    // Back part: root, scaling product, division and saturation.
    cpc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!job_empty),
        .i_job    (job_head),
        .o_take   (job_take),
        .i_stall  (out_full),
        .o_valid  (back_v),
        .o_result (back_result)
    );

    // Result queue seen by the consumer.
    cpc_fifo #(
        .t_item (cpc_pkg::t_result),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_v),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

>>> rtl/core/cpc_fifo.sv
// Small synchronous queue used between the clamp's parts and on its result side.
// Depends on nothing; the item type and depth come from the instantiating module.
module cpc_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer advance with wrap at the last entry.
    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/cpc_front.sv
// Front part of the clamp: takes requests, forms offsets and squares, decides whether to clamp.
// Depends on cpc_pkg.
module cpc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cpc_pkg::t_request i_req,
    input  logic              i_stall,
    output logic              o_valid,
    output cpc_pkg::t_job     o_job
);

    localparam int DW = cpc_pkg::DIFF_WIDTH;
    localparam int RW = cpc_pkg::RAD_WIDTH;
    localparam int SW = cpc_pkg::SUM_WIDTH;
    localparam int PW = 2 * RW;

    // First stage: differences and their magnitudes.
    cpc_pkg::t_request      r_a_req;
    logic signed [DW-1:0]   r_a_dx;
    logic signed [DW-1:0]   r_a_dy;
    logic [DW-1:0]          r_a_mx;
    logic [DW-1:0]          r_a_my;
    logic                   r_a_pos;
    logic                   r_a_v;

    // Second stage: squares.
    cpc_pkg::t_request      r_b_req;
    logic signed [DW-1:0]   r_b_dx;
    logic signed [DW-1:0]   r_b_dy;
    logic [SW-1:0]          r_b_sqx;
    logic [SW-1:0]          r_b_sqy;
    logic [PW-1:0]          r_b_rr;
    logic                   r_b_pos;
    logic                   r_b_v;

    // Third stage: the classified request.
    cpc_pkg::t_job          r_c_job;
    logic                   r_c_v;

    logic signed [DW-1:0]   n_dx;
    logic signed [DW-1:0]   n_dy;
    logic [SW-1:0]          n_sum;
    logic                   adv;

    assign adv     = !i_stall;
    assign o_valid = r_c_v;
    assign o_job   = r_c_job;

    always_comb begin
        n_dx  = DW'(i_req.point_x) - DW'(i_req.anchor_x);
        n_dy  = DW'(i_req.point_y) - DW'(i_req.anchor_y);
        n_sum = r_b_sqx + r_b_sqy;
    end

    // Payload of all three stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_req <= i_req;
            r_a_dx  <= n_dx;
            r_a_dy  <= n_dy;
            r_a_mx  <= n_dx[DW-1] ? DW'(-n_dx) : DW'(n_dx);
            r_a_my  <= n_dy[DW-1] ? DW'(-n_dy) : DW'(n_dy);
            r_a_pos <= (i_req.limit_radius > 0);

            r_b_req <= r_a_req;
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_sqx <= r_a_mx * r_a_mx;
            r_b_sqy <= r_a_my * r_a_my;
            r_b_rr  <= r_a_req.limit_radius[RW-1:0] * r_a_req.limit_radius[RW-1:0];
            r_b_pos <= r_a_pos;

            r_c_job.point_x  <= r_b_req.point_x;
            r_c_job.point_y  <= r_b_req.point_y;
            r_c_job.anchor_x <= r_b_req.anchor_x;
            r_c_job.anchor_y <= r_b_req.anchor_y;
            r_c_job.dx       <= r_b_dx;
            r_c_job.dy       <= r_b_dy;
            r_c_job.radius   <= r_b_req.limit_radius[RW-1:0];
            r_c_job.sum      <= n_sum;
            r_c_job.clamp    <= r_b_pos && (n_sum > SW'(r_b_rr));
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

endmodule

>>> rtl/core/cpc_back.sv
// Back part of the clamp: pipelined square root, scaling product, pipelined division, saturation.
// Depends on cpc_pkg.
module cpc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cpc_pkg::t_job    i_job,
    output logic             o_take,
    input  logic             i_stall,
    output logic             o_valid,
    output cpc_pkg::t_result o_result
);

    localparam int CW = cpc_pkg::COORD_WIDTH;
    localparam int DW = cpc_pkg::DIFF_WIDTH;
    localparam int LW = cpc_pkg::ROOT_WIDTH;
    localparam int SW = cpc_pkg::SUM_WIDTH;
    localparam int NW = cpc_pkg::PROD_WIDTH;
    localparam int MW = LW + 2;
    localparam int NS = LW;
    localparam int OW = CW + 2;

    logic adv;
    assign adv    = !i_stall;
    assign o_take = adv && i_valid;

    // Square root, one result bit per stage.
    cpc_pkg::t_job  sq_job_in  [NS];
    logic [MW-1:0]  sq_rem_in  [NS];
    logic [LW-1:0]  sq_root_in [NS];
    logic           sq_v_in    [NS];
    cpc_pkg::t_job  r_sq_job   [NS];
    logic [MW-1:0]  r_sq_rem   [NS];
    logic [LW-1:0]  r_sq_root  [NS];
    logic           r_sq_v     [NS];

    for (genvar i = 0; i < NS; i++) begin : g_sqrt
        logic [MW-1:0] rs;
        logic [MW-1:0] trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign sq_job_in[i]  = i_job;
            assign sq_rem_in[i]  = '0;
            assign sq_root_in[i] = '0;
            assign sq_v_in[i]    = i_valid;
        end else begin : g_next
            assign sq_job_in[i]  = r_sq_job[i-1];
            assign sq_rem_in[i]  = r_sq_rem[i-1];
            assign sq_root_in[i] = r_sq_root[i-1];
            assign sq_v_in[i]    = r_sq_v[i-1];
        end

        // Bring down the next pair of radicand bits and try the next root bit.
        always_comb begin
            rs    = {sq_rem_in[i][MW-3:0], sq_job_in[i].sum[SW-1-2*i -: 2]};
            trial = {sq_root_in[i], 2'b01};
            ge    = (rs >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_job[i]  <= sq_job_in[i];
                r_sq_rem[i]  <= ge ? rs - trial : rs;
                r_sq_root[i] <= {sq_root_in[i][LW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else if (adv) begin
                r_sq_v[i] <= sq_v_in[i];
            end
        end
    end

    // Scaling products of both offset magnitudes by the radius.
    cpc_pkg::t_job  r_m_job;
    logic [LW-1:0]  r_m_len;
    logic [NW-1:0]  r_m_nx;
    logic [NW-1:0]  r_m_ny;
    logic           r_m_v;
    logic [DW-1:0]  mag_x;
    logic [DW-1:0]  mag_y;
    cpc_pkg::t_job  sq_last;

    assign sq_last = r_sq_job[NS-1];

    always_comb begin
        mag_x = sq_last.dx[DW-1] ? DW'(-sq_last.dx) : DW'(sq_last.dx);
        mag_y = sq_last.dy[DW-1] ? DW'(-sq_last.dy) : DW'(sq_last.dy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_job <= sq_last;
            r_m_len <= r_sq_root[NS-1];
            r_m_nx  <= NW'(mag_x) * NW'(sq_last.radius);
            r_m_ny  <= NW'(mag_y) * NW'(sq_last.radius);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= r_sq_v[NS-1];
        end
    end

    // Restoring division of both products by the length, one quotient bit per stage.
    cpc_pkg::t_job  dv_job_in [NS];
    logic [LW-1:0]  dv_len_in [NS];
    logic [NW-1:0]  dv_nx_in  [NS];
    logic [NW-1:0]  dv_ny_in  [NS];
    logic [LW-1:0]  dv_rx_in  [NS];
    logic [LW-1:0]  dv_ry_in  [NS];
    logic [LW-1:0]  dv_qx_in  [NS];
    logic [LW-1:0]  dv_qy_in  [NS];
    logic           dv_v_in   [NS];
    cpc_pkg::t_job  r_dv_job  [NS];
    logic [LW-1:0]  r_dv_len  [NS];
    logic [NW-1:0]  r_dv_nx   [NS];
    logic [NW-1:0]  r_dv_ny   [NS];
    logic [LW-1:0]  r_dv_rx   [NS];
    logic [LW-1:0]  r_dv_ry   [NS];
    logic [LW-1:0]  r_dv_qx   [NS];
    logic [LW-1:0]  r_dv_qy   [NS];
    logic           r_dv_v    [NS];

    for (genvar j = 0; j < NS; j++) begin : g_div
        logic [LW:0] sx;
        logic [LW:0] sy;
        logic        gx;
        logic        gy;

        if (j == 0) begin : g_first
            assign dv_job_in[j] = r_m_job;
            assign dv_len_in[j] = r_m_len;
            assign dv_nx_in[j]  = r_m_nx;
            assign dv_ny_in[j]  = r_m_ny;
            assign dv_rx_in[j]  = LW'(r_m_nx[NW-1:LW]);
            assign dv_ry_in[j]  = LW'(r_m_ny[NW-1:LW]);
            assign dv_qx_in[j]  = '0;
            assign dv_qy_in[j]  = '0;
            assign dv_v_in[j]   = r_m_v;
        end else begin : g_next
            assign dv_job_in[j] = r_dv_job[j-1];
            assign dv_len_in[j] = r_dv_len[j-1];
            assign dv_nx_in[j]  = r_dv_nx[j-1];
            assign dv_ny_in[j]  = r_dv_ny[j-1];
            assign dv_rx_in[j]  = r_dv_rx[j-1];
            assign dv_ry_in[j]  = r_dv_ry[j-1];
            assign dv_qx_in[j]  = r_dv_qx[j-1];
            assign dv_qy_in[j]  = r_dv_qy[j-1];
            assign dv_v_in[j]   = r_dv_v[j-1];
        end

        // Shift in the next dividend bit and subtract the divisor where it fits.
        always_comb begin
            sx = {dv_rx_in[j], dv_nx_in[j][LW-1-j]};
            sy = {dv_ry_in[j], dv_ny_in[j][LW-1-j]};
            gx = (sx >= {1'b0, dv_len_in[j]});
            gy = (sy >= {1'b0, dv_len_in[j]});
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_job[j] <= dv_job_in[j];
                r_dv_len[j] <= dv_len_in[j];
                r_dv_nx[j]  <= dv_nx_in[j];
                r_dv_ny[j]  <= dv_ny_in[j];
                r_dv_rx[j]  <= gx ? LW'(sx - {1'b0, dv_len_in[j]}) : LW'(sx);
                r_dv_ry[j]  <= gy ? LW'(sy - {1'b0, dv_len_in[j]}) : LW'(sy);
                r_dv_qx[j]  <= {dv_qx_in[j][LW-2:0], gx};
                r_dv_qy[j]  <= {dv_qy_in[j][LW-2:0], gy};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (adv) begin
                r_dv_v[j] <= dv_v_in[j];
            end
        end
    end

    // Signed offsets added to the anchor, saturated, and the pass-through choice.
    cpc_pkg::t_job          dv_last;
    logic signed [OW-1:0]   off_x;
    logic signed [OW-1:0]   off_y;
    logic signed [OW-1:0]   sum_x;
    logic signed [OW-1:0]   sum_y;
    logic signed [OW-1:0]   lim_hi;
    logic signed [OW-1:0]   lim_lo;
    logic                   moved;
    cpc_pkg::t_result       n_result;
    cpc_pkg::t_result       r_result;
    logic                   r_v;

    assign dv_last = r_dv_job[NS-1];

    always_comb begin
        lim_hi = OW'({1'b0, {(CW-1){1'b1}}});
        lim_lo = -lim_hi - OW'(1);
        off_x  = dv_last.dx[DW-1] ? -OW'(r_dv_qx[NS-1]) : OW'(r_dv_qx[NS-1]);
        off_y  = dv_last.dy[DW-1] ? -OW'(r_dv_qy[NS-1]) : OW'(r_dv_qy[NS-1]);
        sum_x  = OW'(dv_last.anchor_x) + off_x;
        sum_y  = OW'(dv_last.anchor_y) + off_y;
        moved  = dv_last.clamp && (r_dv_len[NS-1] != '0);

        n_result.was_clamped = moved;
        if (!moved) begin
            n_result.new_x = dv_last.point_x;
        end else if (sum_x > lim_hi) begin
            n_result.new_x = CW'(lim_hi);
        end else if (sum_x < lim_lo) begin
            n_result.new_x = CW'(lim_lo);
        end else begin
            n_result.new_x = CW'(sum_x);
        end
        if (!moved) begin
            n_result.new_y = dv_last.point_y;
        end else if (sum_y > lim_hi) begin
            n_result.new_y = CW'(lim_hi);
        end else if (sum_y < lim_lo) begin
            n_result.new_y = CW'(lim_lo);
        end else begin
            n_result.new_y = CW'(sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= r_dv_v[NS-1];
        end
    end

    assign o_valid  = r_v && adv;
    assign o_result = r_result;

endmodule
